// ----- sv/wph_pkg.sv -----
// ----------------------------------------------------------------------------
// wph_pkg: shared types and codes of the waypoint horizon planner
// Result codes, header decision codes, widths and the configuration struct.
// ----------------------------------------------------------------------------
`default_nettype none
package wph_pkg;

  // Widths of the arithmetic datapath.
  localparam int unsigned POS_W  = 24;
  localparam int unsigned YAW_W  = 20;
  localparam int unsigned MUL_W  = 26;
  localparam int unsigned PROD_W = 52;
  localparam int unsigned SQ_W   = 50;
  localparam int unsigned ROOT_W = 25;
  localparam int unsigned LEN_W  = 32;

  // Result status codes.
  localparam logic [2:0] ST_READY    = 3'd0;
  localparam logic [2:0] ST_DEGRADED = 3'd1;
  localparam logic [2:0] ST_NOPLAN   = 3'd2;
  localparam logic [2:0] ST_UNSAFE   = 3'd3;
  localparam logic [2:0] ST_STALE    = 3'd4;

  // Result reason codes.
  localparam logic [2:0] RS_NOPLAN     = 3'd0;
  localparam logic [2:0] RS_BLOCKED    = 3'd1;
  localparam logic [2:0] RS_STALE_BLND = 3'd2;
  localparam logic [2:0] RS_STALE_NONE = 3'd3;
  localparam logic [2:0] RS_INFEASIBLE = 3'd4;
  localparam logic [2:0] RS_DEGRADED   = 3'd5;
  localparam logic [2:0] RS_READY      = 3'd6;

  // Decision taken at the header beat.
  localparam logic [2:0] DEC_NOPLAN     = 3'd0;
  localparam logic [2:0] DEC_BLOCKED    = 3'd1;
  localparam logic [2:0] DEC_STALE_BLND = 3'd2;
  localparam logic [2:0] DEC_STALE_NONE = 3'd3;
  localparam logic [2:0] DEC_ROUTE      = 3'd7;

  // Configuration register indexes.
  localparam logic [1:0] REG_HORIZON = 2'd0;
  localparam logic [1:0] REG_MAXSTEP = 2'd1;
  localparam logic [1:0] REG_TIMEOUT = 2'd2;
  localparam logic [1:0] REG_GAIN    = 2'd3;

  localparam logic [16:0] GAIN_ONE = 17'h10000;
  localparam int unsigned BLEND_RND = 32768;

  typedef struct packed {
    logic [23:0] horizon_dist;
    logic [23:0] max_step_dist;
    logic [31:0] stale_timeout_ms;
    logic [16:0] blend_gain;
  } cfg_t;

endpackage
`default_nettype wire

// ----- sv/wph_cfg.sv -----
// ----------------------------------------------------------------------------
// wph_cfg: configuration register file
// APB-style register bank holding horizon, step limit, timeout and gain.
// ----------------------------------------------------------------------------
`default_nettype none
module wph_cfg
  import wph_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_t             cfg
);

  cfg_t cfg_r;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg    = cfg_r;

  // Register writes on the access beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.horizon_dist     <= 24'd65536;
      cfg_r.max_step_dist    <= 24'd32768;
      cfg_r.stale_timeout_ms <= 32'd500;
      cfg_r.blend_gain       <= 17'd32768;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_HORIZON: cfg_r.horizon_dist     <= pwdata[23:0];
        REG_MAXSTEP: cfg_r.max_step_dist    <= pwdata[23:0];
        REG_TIMEOUT: cfg_r.stale_timeout_ms <= pwdata;
        REG_GAIN:    cfg_r.blend_gain       <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  // Read data decode.
  always_comb begin
    unique case (paddr[3:2])
      REG_HORIZON: prdata = {8'd0, cfg_r.horizon_dist};
      REG_MAXSTEP: prdata = {8'd0, cfg_r.max_step_dist};
      REG_TIMEOUT: prdata = cfg_r.stale_timeout_ms;
      REG_GAIN:    prdata = {15'd0, cfg_r.blend_gain};
      default:     prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

// ----- sv/wph_isqrt.sv -----
// ----------------------------------------------------------------------------
// wph_isqrt: iterative floor square root
// Restoring square root, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module wph_isqrt
  import wph_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [SQ_W-1:0]   radicand,
  output logic                   done,
  output logic [ROOT_W-1:0]      root
);

  logic [SQ_W-1:0] v_r, r_r, bit_r;
  logic [SQ_W-1:0] trial;
  logic            busy_r, done_r;

  assign trial = r_r + bit_r;
  assign done  = done_r;
  assign root  = r_r[ROOT_W-1:0];

  // One digit per cycle; the bit walks down two places each step.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        v_r    <= radicand;
        r_r    <= '0;
        bit_r  <= SQ_W'(1) << (SQ_W - 2);
      end else if (busy_r) begin
        if (v_r >= trial) begin
          v_r <= v_r - trial;
          r_r <= (r_r >> 1) + bit_r;
        end else begin
          r_r <= r_r >> 1;
        end
        bit_r <= bit_r >> 2;
        if (bit_r[0]) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- sv/waypoint_horizon_planner.sv -----
// ----------------------------------------------------------------------------
// waypoint_horizon_planner: picks the execution target of a waypoint route
// Headers open a plan, waypoints are measured step by step from the origin,
// one result per plan gives the target, status and reason.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake              | payload
//  in_      | input     | in_valid / in_ready    | header or waypoint beat
//  out_     | output    | out_valid / out_ready  | target, status, reason
//  cfg      | input     | psel/penable/pready    | four registers, 32-bit bus
//
//  A measured waypoint makes two passes through the shared multiplier, one
//  add and then the 25 steps of the square-root unit and its done flag.
//  A stale header with a saved target runs the blend; the last beat of a
//  plan then loads the result in the finish state. in_ready is low while a
//  beat is in work, and loading a result waits while the previous one is
//  still held in the output register.
//  Reset is synchronous and clears all plan and saved state; there is no
//  clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
module waypoint_horizon_planner
  import wph_pkg::*;
#(
  parameter int unsigned MAX_WAYPOINTS = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_kind,
  input  wire logic               in_plan_present,
  input  wire logic               in_blocked,
  input  wire logic [2:0]         in_plan_status,
  input  wire logic [47:0]        in_now_ms,
  input  wire logic [47:0]        in_source_time_ms,
  input  wire logic               in_route_empty,
  input  wire logic signed [23:0] in_pos_x,
  input  wire logic signed [23:0] in_pos_y,
  input  wire logic signed [19:0] in_heading,
  input  wire logic               in_last_point,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    out_cmd_present,
  output logic signed [23:0]      out_target_x,
  output logic signed [23:0]      out_target_y,
  output logic signed [19:0]      out_target_yaw,
  output logic [2:0]              out_status,
  output logic [2:0]              out_reason,
  output logic                    out_fallback_on,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int unsigned CNT_W = $clog2(MAX_WAYPOINTS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_BL_X, S_BL_Y, S_BL_W, S_BL_E,
    S_SQ_X, S_SQ_Y, S_SQ_S, S_ROOT, S_FINISH
  } state_t;

  cfg_t cfg;
  state_t state_r, state_nxt;

  logic signed [23:0] pos_x_r, pos_y_r, saved_x_r, saved_y_r, prev_x_r, prev_y_r;
  logic signed [23:0] chosen_x_r, chosen_y_r;
  logic signed [19:0] hdg_r, saved_yaw_r, chosen_yaw_r;
  logic               saved_valid_r, plan_open_r, chosen_done_r, step_fault_r, last_r;
  logic [2:0]         dec_r, hstat_r;
  logic [LEN_W-1:0]   route_len_r;
  logic [CNT_W-1:0]   wp_cnt_r;
  logic [SQ_W-1:0]    sq_r;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_r;
  logic signed [PROD_W-1:0] blend_p;
  logic signed [MUL_W-1:0]  blend_add;
  logic [16:0]              gain;

  logic        accept, stale, sq_start, root_done;
  logic [ROOT_W-1:0] root;
  logic [LEN_W:0]    len_sum;
  logic [LEN_W-1:0]  len_sat;
  logic              measure;

  wph_cfg u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  wph_isqrt u_isqrt (
    .clk, .rst_n, .start(sq_start), .radicand(sq_r + mul_r[SQ_W-1:0]),
    .done(root_done), .root
  );

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign stale    = {1'b0, in_now_ms} > ({1'b0, in_source_time_ms} + 49'(cfg.stale_timeout_ms));
  assign gain     = (cfg.blend_gain > GAIN_ONE) ? GAIN_ONE : cfg.blend_gain;
  assign sq_start = (state_r == S_SQ_S);
  assign measure  = (dec_r == DEC_ROUTE) && (wp_cnt_r < CNT_W'(MAX_WAYPOINTS));
  assign len_sum  = {1'b0, route_len_r} + (LEN_W + 1)'(root);
  assign len_sat  = len_sum[LEN_W] ? {LEN_W{1'b1}} : len_sum[LEN_W-1:0];

  // Rounded blend step from the registered product: floor((p + 2^15) / 2^16).
  assign blend_p   = mul_r + PROD_W'(BLEND_RND);
  assign blend_add = MUL_W'(blend_p >>> 16);

  // Operand select of the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_BL_X: begin
        mul_a = MUL_W'(pos_x_r) - MUL_W'(saved_x_r);
        mul_b = MUL_W'({1'b0, gain});
      end
      S_BL_Y: begin
        mul_a = MUL_W'(pos_y_r) - MUL_W'(saved_y_r);
        mul_b = MUL_W'({1'b0, gain});
      end
      S_BL_W: begin
        mul_a = MUL_W'(hdg_r) - MUL_W'(saved_yaw_r);
        mul_b = MUL_W'({1'b0, gain});
      end
      S_SQ_X: begin
        mul_a = MUL_W'(pos_x_r) - MUL_W'(prev_x_r);
        mul_b = mul_a;
      end
      S_SQ_Y: begin
        mul_a = MUL_W'(pos_y_r) - MUL_W'(prev_y_r);
        mul_b = mul_a;
      end
      default: ;
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (!in_kind) begin
            if (in_plan_present && !in_blocked && stale && saved_valid_r) state_nxt = S_BL_X;
            else if (in_route_empty) state_nxt = S_FINISH;
          end else if (plan_open_r) begin
            if (measure) state_nxt = S_SQ_X;
            else if (in_last_point) state_nxt = S_FINISH;
          end
        end
      end
      S_BL_X:   state_nxt = S_BL_Y;
      S_BL_Y:   state_nxt = S_BL_W;
      S_BL_W:   state_nxt = S_BL_E;
      S_BL_E:   state_nxt = last_r ? S_FINISH : S_IDLE;
      S_SQ_X:   state_nxt = S_SQ_Y;
      S_SQ_Y:   state_nxt = S_SQ_S;
      S_SQ_S:   state_nxt = S_ROOT;
      S_ROOT:   if (root_done) state_nxt = last_r ? S_FINISH : S_IDLE;
      S_FINISH: if (!out_valid || out_ready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Shared multiplier with its output register.
  always_ff @(posedge clk) begin
    mul_r <= mul_a * mul_b;
  end

  // State, plan state and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      saved_x_r     <= '0;
      saved_y_r     <= '0;
      saved_yaw_r   <= '0;
      saved_valid_r <= 1'b0;
      plan_open_r   <= 1'b0;
      dec_r         <= DEC_NOPLAN;
      hstat_r       <= '0;
      prev_x_r      <= '0;
      prev_y_r      <= '0;
      route_len_r   <= '0;
      chosen_x_r    <= '0;
      chosen_y_r    <= '0;
      chosen_yaw_r  <= '0;
      chosen_done_r <= 1'b0;
      step_fault_r  <= 1'b0;
      wp_cnt_r      <= '0;
      out_valid     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_valid && out_ready && state_r != S_FINISH) out_valid <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            pos_x_r <= in_pos_x;
            pos_y_r <= in_pos_y;
            hdg_r   <= in_heading;
            last_r  <= in_kind ? in_last_point : in_route_empty;
            if (!in_kind) begin
              // Header beat opens a fresh plan.
              plan_open_r   <= 1'b1;
              hstat_r       <= in_plan_status;
              prev_x_r      <= '0;
              prev_y_r      <= '0;
              route_len_r   <= '0;
              chosen_x_r    <= '0;
              chosen_y_r    <= '0;
              chosen_yaw_r  <= '0;
              chosen_done_r <= 1'b0;
              step_fault_r  <= 1'b0;
              wp_cnt_r      <= '0;
              if (!in_plan_present) dec_r <= DEC_NOPLAN;
              else if (in_blocked) dec_r <= DEC_BLOCKED;
              else if (stale) dec_r <= saved_valid_r ? DEC_STALE_BLND : DEC_STALE_NONE;
              else dec_r <= DEC_ROUTE;
            end
          end
        end
        S_BL_Y: chosen_x_r   <= POS_W'(MUL_W'(saved_x_r) + blend_add);
        S_BL_W: chosen_y_r   <= POS_W'(MUL_W'(saved_y_r) + blend_add);
        S_BL_E: chosen_yaw_r <= YAW_W'(MUL_W'(saved_yaw_r) + blend_add);
        S_SQ_Y: sq_r <= mul_r[SQ_W-1:0];
        S_SQ_S: sq_r <= sq_r + mul_r[SQ_W-1:0];
        S_ROOT: begin
          // Step length is in; accumulate, test the step limit and the horizon.
          if (root_done) begin
            if (root > ROOT_W'(cfg.max_step_dist)) step_fault_r <= 1'b1;
            route_len_r <= len_sat;
            prev_x_r    <= pos_x_r;
            prev_y_r    <= pos_y_r;
            wp_cnt_r    <= wp_cnt_r + CNT_W'(1);
            if (!chosen_done_r) begin
              chosen_x_r   <= pos_x_r;
              chosen_y_r   <= pos_y_r;
              chosen_yaw_r <= hdg_r;
              if (len_sat >= LEN_W'(cfg.horizon_dist)) chosen_done_r <= 1'b1;
            end
          end
        end
        S_FINISH: begin
          // Result beat of the plan, loaded once the output register is free.
          if (!out_valid || out_ready) begin
            plan_open_r         <= 1'b0;
            out_valid           <= 1'b1;
            out_cmd_present     <= 1'b0;
            out_target_x        <= '0;
            out_target_y        <= '0;
            out_target_yaw      <= '0;
            out_fallback_on     <= 1'b0;
            unique case (dec_r)
              DEC_NOPLAN: begin
                out_status <= (hstat_r == ST_UNSAFE) ? ST_UNSAFE : ST_NOPLAN;
                out_reason <= RS_NOPLAN;
              end
              DEC_BLOCKED: begin
                out_status <= ST_UNSAFE;
                out_reason <= RS_BLOCKED;
              end
              DEC_STALE_BLND: begin
                out_cmd_present     <= 1'b1;
                out_target_x        <= chosen_x_r;
                out_target_y        <= chosen_y_r;
                out_target_yaw      <= chosen_yaw_r;
                out_status          <= ST_STALE;
                out_reason          <= RS_STALE_BLND;
                out_fallback_on     <= 1'b1;
              end
              DEC_STALE_NONE: begin
                out_status          <= ST_STALE;
                out_reason          <= RS_STALE_NONE;
                out_fallback_on     <= 1'b1;
              end
              default: begin
                if (step_fault_r || wp_cnt_r == '0) begin
                  out_status <= ST_UNSAFE;
                  out_reason <= RS_INFEASIBLE;
                end else begin
                  saved_x_r       <= chosen_x_r;
                  saved_y_r       <= chosen_y_r;
                  saved_yaw_r     <= chosen_yaw_r;
                  saved_valid_r   <= 1'b1;
                  out_cmd_present <= 1'b1;
                  out_target_x    <= chosen_x_r;
                  out_target_y    <= chosen_y_r;
                  out_target_yaw  <= chosen_yaw_r;
                  out_status <= (hstat_r == ST_DEGRADED) ? ST_DEGRADED : ST_READY;
                  out_reason <= (hstat_r == ST_DEGRADED) ? RS_DEGRADED : RS_READY;
                end
              end
            endcase
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- sv/wph_checker.sv -----
// ----------------------------------------------------------------------------
// wph_checker: port-level checks of the waypoint horizon planner
// Watches the result channel over time, during and after reset.
// ----------------------------------------------------------------------------
`default_nettype none
module wph_checker
  import wph_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic               out_cmd_present,
  input wire logic signed [23:0] out_target_x,
  input wire logic signed [23:0] out_target_y,
  input wire logic signed [19:0] out_target_yaw,
  input wire logic [2:0]         out_status,
  input wire logic               out_fallback_on
);

  // A stalled result beat stays valid and holds its status and target x.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_target_x))
    else $error("result beat changed while stalled");

  // No command means zero target fields.
  a_zero_target: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_cmd_present |->
      out_target_x == '0 && out_target_y == '0 && out_target_yaw == '0)
    else $error("target not zero without command");

  // Fallback only on stale results.
  a_fallback: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fallback_on |-> out_status == ST_STALE)
    else $error("fallback on a non-stale result");

  // A live command outside fallback is ready or degraded.
  a_cmd_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_cmd_present && !out_fallback_on |->
      out_status == ST_READY || out_status == ST_DEGRADED)
    else $error("command with wrong status");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind waypoint_horizon_planner wph_checker u_wph_checker (.*);
`default_nettype wire

// ----- test/waypoint_horizon_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waypoint_horizon_checker: result predictor and scoreboard of the planner
// Watches the configuration port and both channels, predicts the result of
// every plan from the accepted beats and compares each result beat with it.
// ----------------------------------------------------------------------------
module waypoint_horizon_checker
  import wph_pkg::*;
#(
  parameter int unsigned MAX_WAYPOINTS = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic               in_ready,
  input  wire logic               in_kind,
  input  wire logic               in_plan_present,
  input  wire logic               in_blocked,
  input  wire logic [2:0]         in_plan_status,
  input  wire logic [47:0]        in_now_ms,
  input  wire logic [47:0]        in_source_time_ms,
  input  wire logic               in_route_empty,
  input  wire logic signed [23:0] in_pos_x,
  input  wire logic signed [23:0] in_pos_y,
  input  wire logic signed [19:0] in_heading,
  input  wire logic               in_last_point,
  input  wire logic               out_valid,
  input  wire logic               out_ready,
  input  wire logic               out_cmd_present,
  input  wire logic signed [23:0] out_target_x,
  input  wire logic signed [23:0] out_target_y,
  input  wire logic signed [19:0] out_target_yaw,
  input  wire logic [2:0]         out_status,
  input  wire logic [2:0]         out_reason,
  input  wire logic               out_fallback_on,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  input  wire logic               pready,
  output int                      fail_count,
  output int                      pending
);

  typedef struct {
    logic                has_cmd;
    logic signed [23:0]  x;
    logic signed [23:0]  y;
    logic signed [19:0]  yaw;
    logic [2:0]          status;
    logic [2:0]          reason;
    logic                fallback;
  } plan_result_t;

  plan_result_t target_queue[$];

  // Shadow configuration.
  cfg_t cfg;

  // Shadow plan state.
  logic signed [23:0] held_x, held_y;
  logic signed [19:0] held_yaw;
  logic               held_valid;
  logic [2:0]         decision, hdr_status;
  logic signed [23:0] last_x, last_y;
  logic [31:0]        path_len;
  logic signed [23:0] pick_x, pick_y;
  logic signed [19:0] pick_yaw;
  logic               pick_locked, too_far, open;
  int unsigned        point_count;

  assign pending = target_queue.size();

  // Floor square root, one result bit at a time.
  function automatic logic [63:0] floor_root(input logic [63:0] v);
    logic [63:0] r, cand;
    r = 0;
    for (int i = 26; i >= 0; i--) begin
      cand = r | (64'd1 << i);
      if (cand * cand <= v) r = cand;
    end
    return r;
  endfunction

  // Move a stored coordinate toward the global one, rounded to nearest.
  function automatic longint blend_axis(input longint from, input longint to);
    longint g, p;
    g = (cfg.blend_gain > GAIN_ONE) ? 65536 : longint'(cfg.blend_gain);
    p = (to - from) * g + 32768;
    return from + (p >>> 16);
  endfunction

  function automatic plan_result_t make_result(input logic cmd,
      input logic signed [23:0] x, input logic signed [23:0] y,
      input logic signed [19:0] yaw, input logic [2:0] st, input logic [2:0] rs,
      input logic fb);
    plan_result_t r;
    r.has_cmd  = cmd;
    r.x        = cmd ? x : '0;
    r.y        = cmd ? y : '0;
    r.yaw      = cmd ? yaw : '0;
    r.status   = st;
    r.reason   = rs;
    r.fallback = fb;
    return r;
  endfunction

  // Close the open plan and queue its result.
  task automatic close_plan();
    plan_result_t r;
    open = 1'b0;
    case (decision)
      DEC_NOPLAN:
        r = make_result(1'b0, 0, 0, 0, (hdr_status == ST_UNSAFE) ? ST_UNSAFE : ST_NOPLAN,
                        RS_NOPLAN, 1'b0);
      DEC_BLOCKED:    r = make_result(1'b0, 0, 0, 0, ST_UNSAFE, RS_BLOCKED, 1'b0);
      DEC_STALE_BLND: r = make_result(1'b1, pick_x, pick_y, pick_yaw, ST_STALE,
                                      RS_STALE_BLND, 1'b1);
      DEC_STALE_NONE: r = make_result(1'b0, 0, 0, 0, ST_STALE, RS_STALE_NONE, 1'b1);
      default: begin
        if (too_far || point_count == 0) begin
          r = make_result(1'b0, 0, 0, 0, ST_UNSAFE, RS_INFEASIBLE, 1'b0);
        end else begin
          held_x = pick_x;
          held_y = pick_y;
          held_yaw = pick_yaw;
          held_valid = 1'b1;
          if (hdr_status == ST_DEGRADED)
            r = make_result(1'b1, pick_x, pick_y, pick_yaw, ST_DEGRADED, RS_DEGRADED, 1'b0);
          else
            r = make_result(1'b1, pick_x, pick_y, pick_yaw, ST_READY, RS_READY, 1'b0);
        end
      end
    endcase
    target_queue.push_back(r);
  endtask

  // Header beat: reset the route and take the first decision.
  task automatic take_header();
    logic [63:0] deadline;
    hdr_status = in_plan_status;
    last_x = 0;
    last_y = 0;
    path_len = 0;
    pick_x = 0;
    pick_y = 0;
    pick_yaw = 0;
    pick_locked = 1'b0;
    too_far = 1'b0;
    point_count = 0;
    deadline = 64'(in_source_time_ms) + 64'(cfg.stale_timeout_ms);
    if (!in_plan_present) begin
      decision = DEC_NOPLAN;
    end else if (in_blocked) begin
      decision = DEC_BLOCKED;
    end else if (64'(in_now_ms) > deadline) begin
      if (held_valid) begin
        decision = DEC_STALE_BLND;
        pick_x = 24'(blend_axis(held_x, in_pos_x));
        pick_y = 24'(blend_axis(held_y, in_pos_y));
        pick_yaw = 20'(blend_axis(held_yaw, in_heading));
      end else begin
        decision = DEC_STALE_NONE;
      end
    end else begin
      decision = DEC_ROUTE;
    end
    open = 1'b1;
    if (in_route_empty) close_plan();
  endtask

  // Waypoint beat: measure the step and track the horizon point.
  task automatic take_waypoint();
    longint dx, dy;
    logic [63:0] step, total;
    if (!open) return;
    if (decision == DEC_ROUTE && point_count < MAX_WAYPOINTS) begin
      dx = longint'(in_pos_x) - longint'(last_x);
      dy = longint'(in_pos_y) - longint'(last_y);
      step = floor_root(64'(dx * dx) + 64'(dy * dy));
      total = 64'(path_len) + step;
      if (step > 64'(cfg.max_step_dist)) too_far = 1'b1;
      path_len = (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
      last_x = in_pos_x;
      last_y = in_pos_y;
      if (!pick_locked) begin
        pick_x = in_pos_x;
        pick_y = in_pos_y;
        pick_yaw = in_heading;
        if (path_len >= 32'(cfg.horizon_dist)) pick_locked = 1'b1;
      end
      point_count++;
    end
    if (in_last_point) close_plan();
  endtask

  task automatic compare_result();
    plan_result_t e;
    if (target_queue.size() == 0) begin
      $error("result beat with no plan result waiting");
      fail_count++;
      return;
    end
    e = target_queue.pop_front();
    if (out_cmd_present !== e.has_cmd) begin
      $error("cmd_present: expected %0d, got %0d", e.has_cmd, out_cmd_present);
      fail_count++;
    end
    if (out_target_x !== e.x) begin
      $error("target_x: expected %0d, got %0d", e.x, out_target_x);
      fail_count++;
    end
    if (out_target_y !== e.y) begin
      $error("target_y: expected %0d, got %0d", e.y, out_target_y);
      fail_count++;
    end
    if (out_target_yaw !== e.yaw) begin
      $error("target_yaw: expected %0d, got %0d", e.yaw, out_target_yaw);
      fail_count++;
    end
    if (out_status !== e.status) begin
      $error("status: expected %0d, got %0d", e.status, out_status);
      fail_count++;
    end
    if (out_reason !== e.reason) begin
      $error("reason: expected %0d, got %0d", e.reason, out_reason);
      fail_count++;
    end
    if (out_fallback_on !== e.fallback) begin
      $error("fallback_on: expected %0d, got %0d", e.fallback, out_fallback_on);
      fail_count++;
    end
  endtask

  initial fail_count = 0;

  // Track every edge: reset, register writes, input beats, result beats.
  always @(posedge clk) begin
    if (!rst_n) begin
      cfg.horizon_dist <= 24'd65536;
      cfg.max_step_dist <= 24'd32768;
      cfg.stale_timeout_ms <= 32'd500;
      cfg.blend_gain <= 17'd32768;
      held_x = 0;
      held_y = 0;
      held_yaw = 0;
      held_valid = 1'b0;
      decision = DEC_NOPLAN;
      hdr_status = ST_READY;
      last_x = 0;
      last_y = 0;
      path_len = 0;
      pick_x = 0;
      pick_y = 0;
      pick_yaw = 0;
      pick_locked = 1'b0;
      too_far = 1'b0;
      open = 1'b0;
      point_count = 0;
      target_queue.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_HORIZON: cfg.horizon_dist <= pwdata[23:0];
          REG_MAXSTEP: cfg.max_step_dist <= pwdata[23:0];
          REG_TIMEOUT: cfg.stale_timeout_ms <= pwdata;
          REG_GAIN:    cfg.blend_gain <= pwdata[16:0];
        endcase
      end
      if (out_valid && out_ready) compare_result();
      if (in_valid && in_ready) begin
        if (in_kind) take_waypoint();
        else take_header();
      end
    end
  end

endmodule

// ----- test/waypoint_horizon_planner_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waypoint_horizon_planner_test: top of the planner testbench
// Drives directed and random plans through the input channel under several
// idling phases and register settings; the checker predicts and compares.
// ----------------------------------------------------------------------------
module waypoint_horizon_planner_test;
  import wph_pkg::*;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic               in_kind;
  logic               in_plan_present;
  logic               in_blocked;
  logic [2:0]         in_plan_status;
  logic [47:0]        in_now_ms;
  logic [47:0]        in_source_time_ms;
  logic               in_route_empty;
  logic signed [23:0] in_pos_x;
  logic signed [23:0] in_pos_y;
  logic signed [19:0] in_heading;
  logic               in_last_point;
  logic               out_valid;
  logic               out_ready;
  logic               out_cmd_present;
  logic signed [23:0] out_target_x;
  logic signed [23:0] out_target_y;
  logic signed [19:0] out_target_yaw;
  logic [2:0]         out_status;
  logic [2:0]         out_reason;
  logic               out_fallback_on;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [3:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  int fail_count;
  int pending;
  int idle_pct;
  int stall_pct;
  int beats_sent;
  int unsigned step_reach;
  int unsigned timeout_now;

  waypoint_horizon_planner uut (.*);

  waypoint_horizon_checker scoreboard (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4ms;
    $display("FAILED: results differ");
    $finish;
  end

  // Result side stalls at the phase's rate.
  initial out_ready = 1'b0;
  always @(posedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Drop valid and wait until every result is in and the block is idle.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  task automatic set_config(input logic [23:0] hz, input logic [23:0] ms,
                            input logic [31:0] to, input logic [16:0] g);
    drain();
    reg_write(REG_HORIZON, 32'(hz));
    reg_write(REG_MAXSTEP, 32'(ms));
    reg_write(REG_TIMEOUT, to);
    reg_write(REG_GAIN, 32'(g));
    step_reach = (ms == 0) ? 24'h100 : ms;
    timeout_now = to;
  endtask

  // One input beat; valid stays high across back-to-back beats.
  task automatic send_beat(input logic kind, input logic present, input logic blocked,
      input logic [2:0] st, input logic [47:0] now, input logic [47:0] src,
      input logic empty, input logic signed [23:0] x, input logic signed [23:0] y,
      input logic signed [19:0] yaw, input logic last);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_plan_present <= present;
    in_blocked <= blocked;
    in_plan_status <= st;
    in_now_ms <= now;
    in_source_time_ms <= src;
    in_route_empty <= empty;
    in_pos_x <= x;
    in_pos_y <= y;
    in_heading <= yaw;
    in_last_point <= last;
    do @(posedge clk); while (!in_ready);
    beats_sent++;
  endtask

  task automatic send_header(input logic present, input logic blocked, input logic [2:0] st,
      input logic [47:0] now, input logic [47:0] src, input logic empty,
      input logic signed [23:0] x, input logic signed [23:0] y, input logic signed [19:0] yaw);
    send_beat(1'b0, present, blocked, st, now, src, empty, x, y, yaw, 1'($urandom));
  endtask

  task automatic send_point(input logic signed [23:0] x, input logic signed [23:0] y,
                            input logic signed [19:0] yaw, input logic last);
    send_beat(1'b1, 1'($urandom), 1'($urandom), 3'($urandom), 48'({$urandom, $urandom}),
              48'({$urandom, $urandom}), 1'($urandom), x, y, yaw, last);
  endtask

  // One random plan: mostly fresh routes of a few waypoints, some broken.
  task automatic random_plan();
    int unsigned roll, count;
    logic [47:0] src, now;
    logic hp, bl, empty;
    longint px, py, reach;
    roll = $urandom_range(99);
    src = ($urandom_range(3) == 0) ? 48'({$urandom, $urandom}) : 48'($urandom);
    if (roll < 12) now = src + 48'(timeout_now) + 48'($urandom_range(1, 50));
    else if (roll < 16) now = 48'({$urandom, $urandom});
    else now = src + 48'($urandom_range(0, 400));
    if (timeout_now > 400 && roll >= 16) now = src + 48'($urandom_range(0, 400));
    hp = ($urandom_range(9) != 0);
    bl = ($urandom_range(11) == 0);
    empty = ($urandom_range(11) == 0);
    send_header(hp, bl, 3'($urandom_range(4)), now, src, empty,
                24'($urandom), 24'($urandom), 20'($urandom));
    if (empty) return;
    count = ($urandom_range(29) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 6);
    px = 0;
    py = 0;
    reach = ($urandom_range(4) == 0) ? 2 * longint'(step_reach) : longint'(step_reach);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(19) == 0) begin
        px = longint'(24'($urandom));
        py = longint'(24'($urandom));
      end else begin
        px += longint'($urandom_range(0, 2 * reach)) - reach;
        py += longint'($urandom_range(0, 2 * reach)) - reach;
        if (px > 8388607) px = 8388607;
        if (px < -8388608) px = -8388608;
        if (py > 8388607) py = 8388607;
        if (py < -8388608) py = -8388608;
      end
      // Now and then a new header cuts the plan short.
      if (i + 1 < count && $urandom_range(49) == 0) return;
      send_point(24'(px), 24'(py), 20'($urandom), i + 1 == count);
    end
  endtask

  task automatic random_phase(input int idle, input int stall, input int beats);
    int stop;
    idle_pct = idle;
    stall_pct = stall;
    stop = beats_sent + beats;
    while (beats_sent < stop) begin
      if ($urandom_range(24) == 0) begin
        send_point(24'($urandom), 24'($urandom), 20'($urandom), 1'($urandom));
      end else begin
        random_plan();
      end
      if ($urandom_range(59) == 0) drain();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_kind = 1'b0;
    in_plan_present = 1'b0;
    in_blocked = 1'b0;
    in_plan_status = '0;
    in_now_ms = '0;
    in_source_time_ms = '0;
    in_route_empty = 1'b0;
    in_pos_x = '0;
    in_pos_y = '0;
    in_heading = '0;
    in_last_point = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    idle_pct = 0;
    stall_pct = 0;
    beats_sent = 0;
    step_reach = 32768;
    timeout_now = 500;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: each decision, the extremes and the odd cases.
    send_point(24'sd100, 24'sd100, 20'sd5, 1'b1);
    send_header(1'b0, 1'b0, ST_UNSAFE, 48'd0, 48'd0, 1'b1, 0, 0, 0);
    send_header(1'b0, 1'b0, ST_READY, 48'd0, 48'd0, 1'b1, 0, 0, 0);
    send_header(1'b1, 1'b1, ST_READY, 48'd10, 48'd10, 1'b1, 0, 0, 0);
    send_header(1'b1, 1'b0, ST_STALE, 48'hFFFF_FFFF_FFFF, 48'd0, 1'b1, 0, 0, 0);
    send_header(1'b1, 1'b0, ST_READY, 48'd100, 48'd0, 1'b1, 0, 0, 0);
    send_header(1'b1, 1'b0, ST_READY, 48'd500, 48'd0, 1'b0, 0, 0, 0);
    send_point(24'sd20000, 24'sd0, 20'sd100, 1'b0);
    send_point(24'sd40000, 24'sd20000, -20'sd100, 1'b0);
    send_point(24'sd60000, 24'sd40000, 20'sd524287, 1'b0);
    send_point(24'sd70000, 24'sd60000, -20'sd524288, 1'b1);
    send_header(1'b1, 1'b0, ST_DEGRADED, 48'd0, 48'd0, 1'b0, 0, 0, 0);
    send_point(-24'sd30000, 24'sd0, 20'sd77, 1'b1);
    send_header(1'b1, 1'b0, ST_READY, 48'd501, 48'd0, 1'b0,
                24'sd8388607, -24'sd8388608, 20'sd524287);
    send_point(24'sd1, 24'sd1, 20'sd1, 1'b1);
    send_header(1'b1, 1'b0, ST_READY, 48'd0, 48'd0, 1'b0, 0, 0, 0);
    send_point(24'sd8388607, -24'sd8388608, 20'sd0, 1'b1);
    send_header(1'b1, 1'b0, ST_READY, 48'd0, 48'd0, 1'b0, 0, 0, 0);
    send_header(1'b1, 1'b0, ST_DEGRADED, 48'd0, 48'd0, 1'b0, 0, 0, 0);
    send_point(24'sd10, -24'sd10, -20'sd3, 1'b1);
    send_header(1'b1, 1'b0, ST_READY, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b0,
                -24'sd8388608, 24'sd8388607, -20'sd524288);
    send_point(0, 0, 0, 1'b1);

    // Random phases across register settings, extremes first.
    set_config(24'd0, 24'hFF_FFFF, 32'd0, 17'd0);
    random_phase(0, 0, 60);
    // Let everything drain before the next plan.
    drain();
    set_config(24'hFF_FFFF, 24'd0, 32'hFFFF_FFFF, 17'h1_FFFF);
    random_phase(63, 0, 40);
    set_config(24'd65536, 24'd32768, 32'd500, 17'h1_0000);
    random_phase(63, 0, 60);
    set_config(24'($urandom_range(1, 24'h4_0000)), 24'($urandom_range(4096, 24'h2_0000)),
               32'($urandom_range(0, 300)), 17'($urandom_range(0, 17'h1_0000)));
    random_phase(0, 63, 100);
    set_config(24'd131072, 24'h7F_FFFF, 32'd50, 17'd1);
    random_phase(16, 16, 100);
    random_phase(0, 0, 40);

    // Drain and give the verdict.
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
